[hdl/nlqt_pkg.sv]
package nlqt_pkg;

  // table geometry
  localparam int NLQT_ENTRIES = 10;

  // field widths
  localparam int ADDR_W  = 16;
  localparam int RAW_W   = 5;
  localparam int LQI_W   = 8;
  localparam int RSSI_W  = 8;
  localparam int SCALE_W = 3;
  localparam int ENTRY_W = 4;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_RSSI_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RSSI_SCALE  = 1'd1;

  localparam logic signed [RSSI_W-1:0] RSSI_OFFSET_RST = -8'sd94;
  localparam logic [SCALE_W-1:0]       RSSI_SCALE_RST  = 3'd3;

  // smoothing: (8*old + 2*new)/10 == (4*old + new)/5
  localparam int SUM_W    = 11;
  localparam int RECIP_SH = 14;
  localparam int RECIP    = ((1 << RECIP_SH) + 4) / 5;
  localparam int PROD_W   = 23;

  // search token handed from cell to cell
  typedef struct packed {
    logic                     valid;
    logic                     done;
    logic                     was_new;
    logic signed [RSSI_W-1:0] old_rssi;
    logic [LQI_W-1:0]         old_lqi;
  } tok_t;

endpackage

[hdl/nlqt_cell.sv]
module nlqt_cell
  import nlqt_pkg::*;
#(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tok_t                     tok_i,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic [ADDR_W-1:0]        req_addr,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [RSSI_W-1:0] wr_rssi,
  input  logic [LQI_W-1:0]         wr_lqi,
  output tok_t                     tok_o,
  output logic [IDX_W-1:0]         idx_o
);

  logic [ADDR_W-1:0]        addr_r;
  logic signed [RSSI_W-1:0] rssi_r;
  logic [LQI_W-1:0]         lqi_r;
  logic                     filled_r;
  tok_t                     tok_r, tok_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;

  // claim the request on a filled match, or on the first empty slot
  always_comb begin
    tok_nxt = tok_i;
    idx_nxt = idx_i;
    if (tok_i.valid && !tok_i.done) begin
      if (filled_r && (addr_r == req_addr)) begin
        tok_nxt.done     = 1'b1;
        tok_nxt.was_new  = 1'b0;
        tok_nxt.old_rssi = rssi_r;
        tok_nxt.old_lqi  = lqi_r;
        idx_nxt          = IDX_W'(CELL_IDX);
      end else if (!filled_r) begin
        tok_nxt.done    = 1'b1;
        tok_nxt.was_new = 1'b1;
        idx_nxt         = IDX_W'(CELL_IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= 1'b0;
      tok_r    <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (wr_en) begin
        filled_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (wr_en) begin
      addr_r <= wr_addr;
      rssi_r <= wr_rssi;
      lqi_r  <= wr_lqi;
    end
  end

  assign tok_o = tok_r;
  assign idx_o = idx_r;

endmodule

[hdl/nlqt_smooth.sv]
module nlqt_smooth
  import nlqt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic signed [RSSI_W-1:0] old_rssi,
  input  logic signed [RSSI_W-1:0] new_rssi,
  input  logic [LQI_W-1:0]         old_lqi,
  input  logic [LQI_W-1:0]         new_lqi,
  output logic                     out_valid,
  output logic signed [RSSI_W-1:0] rssi,
  output logic [LQI_W-1:0]         lqi
);

  logic signed [SUM_W-1:0]  rsum;
  logic [SUM_W-1:0]         rmag;
  logic [SUM_W-1:0]         lsum;
  logic [PROD_W-1:0]        rprod_r, lprod_r;
  logic                     neg_r, v1_r, v2_r;
  logic [RSSI_W-1:0]        rq;
  logic signed [RSSI_W-1:0] rssi_r;
  logic [LQI_W-1:0]         lqi_r;

  // stage 1: 4*old + new, magnitude, times reciprocal of five
  always_comb begin
    rsum = {{(SUM_W-RSSI_W-2){old_rssi[RSSI_W-1]}}, old_rssi, 2'b00}
         + {{(SUM_W-RSSI_W){new_rssi[RSSI_W-1]}}, new_rssi};
    rmag = rsum[SUM_W-1] ? SUM_W'(-rsum) : SUM_W'(rsum);
    lsum = {{(SUM_W-LQI_W-2){1'b0}}, old_lqi, 2'b00}
         + {{(SUM_W-LQI_W){1'b0}}, new_lqi};
  end

  // both stages hold their value until the next request
  always_ff @(posedge clk) begin
    if (in_valid) begin
      rprod_r <= PROD_W'(rmag) * PROD_W'(RECIP);
      lprod_r <= PROD_W'(lsum) * PROD_W'(RECIP);
      neg_r   <= rsum[SUM_W-1];
    end
  end

  // stage 2: shift down, restore sign (truncation toward zero)
  assign rq = rprod_r[RECIP_SH +: RSSI_W];

  always_ff @(posedge clk) begin
    if (v1_r) begin
      rssi_r <= neg_r ? $signed(-rq) : $signed(rq);
      lqi_r  <= lprod_r[RECIP_SH +: LQI_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign out_valid = v2_r;
  assign rssi      = rssi_r;
  assign lqi       = lqi_r;

endmodule

[hdl/neighbor_link_quality_table.sv]
// Neighbor link-quality table. Each request on in_ carries one received frame
// (sender short address, raw RSSI, LQI); the raw RSSI is turned into dBm as
// rssi_offset + rssi_scale*raw, saturated to a signed byte. The request then
// walks a row of TABLE_ENTRIES cells, one cell per cycle: a filled cell with
// the same address takes it and the stored RSSI/LQI are smoothed as
// (8*old + 2*new)/10, truncating toward zero; otherwise the first empty cell
// takes it as a new neighbor; if neither happens the table is full, nothing
// is stored and table_full is reported. One result per request. A request
// passes from acceptance through launch_r, the walk through the cell row,
// the two-stage divide-by-five unit and the ST_CALC and ST_DONE states to a
// result in the output register; in_tready comes back in the cycle after
// that result is loaded, even while it still waits on out_tready, so a new
// request is taken only once the last one's result is loaded. Writes on
// cfg_ are taken at any time and should only be made while no request is
// in flight.
module neighbor_link_quality_table
  import nlqt_pkg::*;
#(
  parameter int TABLE_ENTRIES = NLQT_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // source_address[15:0], raw_rssi[20:16],
                                            // link_quality[28:21], zero[31:29]
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // entry_index[3:0], smoothed_rssi[11:4],
                                            // smoothed_lqi[19:12], zero[23:20]
  output logic [1:0]            out_tuser,  // was_new[0], table_full[1]
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_CALC   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic signed [RSSI_W-1:0] rssi_offset_r;
  logic [SCALE_W-1:0]       rssi_scale_r;

  // request registers, broadcast to every cell during the walk
  logic [ADDR_W-1:0]        req_addr_r;
  logic signed [RSSI_W-1:0] req_rssi_r;
  logic [LQI_W-1:0]         req_lqi_r;
  logic                     launch_r;

  // what came out of the end of the row
  logic                     tail_done_r;
  logic                     tail_new_r;
  logic [IDX_W-1:0]         tail_idx_r;

  // output register
  logic                     out_valid_r;
  logic [ENTRY_W-1:0]       out_idx_r;
  logic                     out_new_r;
  logic                     out_full_r;
  logic signed [RSSI_W-1:0] out_rssi_r;
  logic [LQI_W-1:0]         out_lqi_r;

  logic                     in_acc;
  logic                     load;
  logic [ADDR_W-1:0]        in_addr;
  logic [RAW_W-1:0]         in_raw;
  logic [LQI_W-1:0]         in_lqi;
  logic [RSSI_W-1:0]        conv_prod;
  logic signed [RSSI_W+1:0] conv_sum;
  logic signed [RSSI_W-1:0] conv_rssi;

  tok_t                     tok_w [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]         idx_w [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] cell_wr;
  logic                     wr_en;
  logic signed [RSSI_W-1:0] wr_rssi;
  logic [LQI_W-1:0]         wr_lqi;

  logic                     sm_in_valid;
  logic                     sm_valid;
  logic signed [RSSI_W-1:0] sm_rssi;
  logic [LQI_W-1:0]         sm_lqi;

  assign in_addr = in_tdata[15:0];
  assign in_raw  = in_tdata[20:16];
  assign in_lqi  = in_tdata[28:21];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // dBm conversion, saturated at the top (offset is never below -128)
  always_comb begin
    conv_prod = RSSI_W'(rssi_scale_r) * RSSI_W'(in_raw);
    conv_sum  = {{2{rssi_offset_r[RSSI_W-1]}}, rssi_offset_r}
              + $signed({2'b00, conv_prod});
    if (conv_sum > (RSSI_W+2)'(127)) begin
      conv_rssi = 8'sd127;
    end else begin
      conv_rssi = conv_sum[RSSI_W-1:0];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rssi_offset_r <= RSSI_OFFSET_RST;
      rssi_scale_r  <= RSSI_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RSSI_OFFSET: rssi_offset_r <= cfg_data[RSSI_W-1:0];
        REG_RSSI_SCALE:  rssi_scale_r  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_addr_r <= in_addr;
      req_rssi_r <= conv_rssi;
      req_lqi_r  <= in_lqi;
    end
  end

  // token enters cell 0 the cycle after acceptance
  always_comb begin
    tok_w[0]       = '0;
    tok_w[0].valid = launch_r;
    idx_w[0]       = '0;
  end

  // the row of cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    assign cell_wr[g] = wr_en && (tail_idx_r == IDX_W'(g));

    nlqt_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_i    (tok_w[g]),
      .idx_i    (idx_w[g]),
      .req_addr (req_addr_r),
      .wr_en    (cell_wr[g]),
      .wr_addr  (req_addr_r),
      .wr_rssi  (wr_rssi),
      .wr_lqi   (wr_lqi),
      .tok_o    (tok_w[g+1]),
      .idx_o    (idx_w[g+1])
    );
  end

  // smoothing runs on every request, used only on a hit
  assign sm_in_valid = (state_r == ST_SEARCH) && tok_w[TABLE_ENTRIES].valid;

  nlqt_smooth u_smooth (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sm_in_valid),
    .old_rssi  (tok_w[TABLE_ENTRIES].old_rssi),
    .new_rssi  (req_rssi_r),
    .old_lqi   (tok_w[TABLE_ENTRIES].old_lqi),
    .new_lqi   (req_lqi_r),
    .out_valid (sm_valid),
    .rssi      (sm_rssi),
    .lqi       (sm_lqi)
  );

  always_ff @(posedge clk) begin
    if (sm_in_valid) begin
      tail_done_r <= tok_w[TABLE_ENTRIES].done;
      tail_new_r  <= tok_w[TABLE_ENTRIES].was_new;
      tail_idx_r  <= idx_w[TABLE_ENTRIES];
    end
  end

  // result is committed and the table written in the same cycle
  assign load    = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign wr_en   = load && tail_done_r;
  assign wr_rssi = tail_new_r ? req_rssi_r : sm_rssi;
  assign wr_lqi  = tail_new_r ? req_lqi_r : sm_lqi;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_SEARCH;
      ST_SEARCH: if (tok_w[TABLE_ENTRIES].valid) state_nxt = ST_CALC;
      ST_CALC:   if (sm_valid) state_nxt = ST_DONE;
      ST_DONE:   if (load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_acc;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload; a dropped request reports zeros and table_full
  always_ff @(posedge clk) begin
    if (load) begin
      if (tail_done_r) begin
        out_idx_r  <= ENTRY_W'(tail_idx_r);
        out_new_r  <= tail_new_r;
        out_full_r <= 1'b0;
        out_rssi_r <= wr_rssi;
        out_lqi_r  <= wr_lqi;
      end else begin
        out_idx_r  <= '0;
        out_new_r  <= 1'b0;
        out_full_r <= 1'b1;
        out_rssi_r <= '0;
        out_lqi_r  <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_lqi_r, out_rssi_r, out_idx_r};
  assign out_tuser  = {out_full_r, out_new_r};

endmodule

[tb/tb_neighbor_link_quality_table.sv]
`timescale 1ns / 1ps

module tb_neighbor_link_quality_table;
  import nlqt_pkg::*;

  // request to result is the cell walk plus the divider, see the block header
  localparam int LINK_LAT         = NLQT_ENTRIES + 5;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PHASES    = 7;
  localparam int FRAMES_PER_PHASE = 150;
  localparam int REPORT_CAP       = 60;

  // one received frame as the block sees it
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [RAW_W-1:0]  raw;
    logic [LQI_W-1:0]  lqi;
  } frame_t;

  // one table update as reported on out_
  typedef struct {
    logic [ENTRY_W-1:0]       entry;
    logic                     was_new;
    logic                     full;
    logic signed [RSSI_W-1:0] rssi;
    logic [LQI_W-1:0]         lqi;
  } link_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  neighbor_link_quality_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow copy of the neighbor table and the conversion registers
  logic [ADDR_W-1:0]        nb_addr [NLQT_ENTRIES];
  int                       nb_rssi [NLQT_ENTRIES];
  int                       nb_lqi  [NLQT_ENTRIES];
  int                       nb_filled    = 0;
  logic signed [RSSI_W-1:0] model_offset = RSSI_OFFSET_RST;
  logic [SCALE_W-1:0]       model_scale  = RSSI_SCALE_RST;

  frame_t frame_pending [$];   // frames not yet put on in_
  frame_t frame_on_bus;        // frame currently offered on in_
  link_t  due_links [$];       // predicted updates, oldest first

  int cycle_count   = 0;
  int err_count     = 0;
  int links_checked = 0;
  int hit_count     = 0;
  int new_count     = 0;
  int full_count    = 0;
  int cfg_writes    = 0;

  // random back-pressure, with a quiet window at the start of each period of the cycle counter
  function automatic bit idle_now();
    return (cycle_count % 20000 >= 5000) && ($urandom_range(99) < 30);
  endfunction

  // table lookup and update for one frame
  function automatic link_t update_neighbor(frame_t f);
    link_t r;
    int    dbm;
    int    slot;
    r.entry   = '0;
    r.was_new = 1'b0;
    r.full    = 1'b0;
    r.rssi    = '0;
    r.lqi     = '0;
    // raw reading to dBm, clamped to a signed byte
    dbm = int'(model_offset) + int'(model_scale) * int'(f.raw);
    if (dbm > 127) dbm = 127;
    if (dbm < -128) dbm = -128;
    // only filled slots are searched, lowest match wins
    slot = -1;
    for (int i = 0; i < nb_filled; i++) begin
      if (slot < 0 && nb_addr[i] == f.addr) slot = i;
    end
    if (slot >= 0) begin
      // smoothing truncates toward zero, also for negative dBm
      nb_rssi[slot] = (8 * nb_rssi[slot] + 2 * dbm) / 10;
      nb_lqi[slot]  = (8 * nb_lqi[slot] + 2 * int'(f.lqi)) / 10;
      hit_count++;
    end else if (nb_filled < NLQT_ENTRIES) begin
      slot          = nb_filled;
      nb_addr[slot] = f.addr;
      nb_rssi[slot] = dbm;
      nb_lqi[slot]  = int'(f.lqi);
      nb_filled++;
      r.was_new = 1'b1;
      new_count++;
    end else begin
      // dropped frame: table untouched, all other fields zero
      r.full = 1'b1;
      full_count++;
      return r;
    end
    r.entry = ENTRY_W'(slot);
    r.rssi  = RSSI_W'(nb_rssi[slot]);
    r.lqi   = LQI_W'(nb_lqi[slot]);
    return r;
  endfunction

  // mostly frames from known neighbors, the rest random senders
  function automatic frame_t random_frame();
    frame_t f;
    if (nb_filled != 0 && $urandom_range(99) < 75) begin
      f.addr = nb_addr[$urandom_range(nb_filled - 1)];
    end else begin
      f.addr = ADDR_W'($urandom);
    end
    f.raw = RAW_W'($urandom);
    f.lqi = LQI_W'($urandom);
    return f;
  endfunction

  task automatic add_frame(input int addr, input int raw, input int lqi);
    frame_t f;
    f.addr = ADDR_W'(addr);
    f.raw  = RAW_W'(raw);
    f.lqi  = LQI_W'(lqi);
    frame_pending.push_back(f);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < REPORT_CAP)
      $display("mismatch at cycle %0d on %s: got %0d, want %0d", cycle_count, what, got, want);
    err_count++;
  endtask

  // register write, only issued while no request is in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RSSI_OFFSET: model_offset = val;
      REG_RSSI_SCALE:  model_scale  = val[SCALE_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic wait_idle();
    while (frame_pending.size() != 0 || in_tvalid || due_links.size() != 0)
      @(posedge clk);
  endtask

  // request driver: holds a frame until taken, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) due_links.push_back(update_neighbor(frame_on_bus));
      if (!in_tvalid || in_tready) begin
        if (frame_pending.size() != 0 && !idle_now()) begin
          frame_on_bus = frame_pending.pop_front();
          in_tvalid <= 1'b1;
          // link_quality, raw_rssi, source_address from the top bits down
          in_tdata  <= {3'b000, frame_on_bus.lqi, frame_on_bus.raw, frame_on_bus.addr};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !idle_now();
    end
  end

  // result monitor: field by field against the oldest prediction
  always @(posedge clk) begin
    link_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_links.size() == 0) begin
        report_mismatch("result with nothing due", 1, 0);
      end else begin
        want = due_links.pop_front();
        if (out_tdata[3:0] !== want.entry)
          report_mismatch("entry_index", int'(out_tdata[3:0]), int'(want.entry));
        if (out_tuser[0] !== want.was_new)
          report_mismatch("was_new", int'(out_tuser[0]), int'(want.was_new));
        if (out_tuser[1] !== want.full)
          report_mismatch("table_full", int'(out_tuser[1]), int'(want.full));
        if (out_tdata[11:4] !== want.rssi)
          report_mismatch("smoothed_rssi", int'($signed(out_tdata[11:4])), int'(want.rssi));
        if (out_tdata[19:12] !== want.lqi)
          report_mismatch("smoothed_lqi", int'(out_tdata[19:12]), int'(want.lqi));
        if (out_tdata[23:20] !== 4'b0000)
          report_mismatch("tdata padding", int'(out_tdata[23:20]), 0);
        links_checked++;
      end
    end
  end

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               due_links.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int offs;
    int scl;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table under reset settings: extremes first, then a zero address
    // that must not match the unfilled zero slots
    add_frame(16'hFFFF, 31, 255);
    add_frame(16'h0000, 0, 0);
    add_frame(16'h0000, 31, 255);
    repeat (3) add_frame(16'hFFFF, 0, 0);
    // fill the rest of the table
    add_frame(16'h0001, 7, 1);
    add_frame(16'h8000, 16, 128);
    add_frame(16'h5555, 21, 85);
    add_frame(16'hAAAA, 10, 170);
    add_frame(16'h00FF, 1, 254);
    add_frame(16'hFF00, 30, 2);
    add_frame(16'h1234, 12, 100);
    add_frame(16'h4321, 25, 200);
    // misses on a full table are dropped
    add_frame(16'hBEEF, 31, 255);
    add_frame(16'h7FFF, 0, 0);
    // hits still work once full
    add_frame(16'h4321, 0, 0);
    add_frame(16'h4321, 31, 255);
    add_frame(16'h0000, 5, 9);
    wait_idle();

    // random traffic under a run of conversion settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin offs = -128; scl = 0; end   // lowest dBm, no slope
        1: begin offs = 0;    scl = 7; end   // steepest slope, clamps high
        2: begin offs = int'(RSSI_OFFSET_RST); scl = int'(RSSI_SCALE_RST); end
        3: begin offs = -1;   scl = 1; end
        default: begin
          offs = -int'($urandom_range(128));
          scl  = $urandom_range(7);
        end
      endcase
      write_reg(REG_RSSI_OFFSET, CFG_DATA_W'(offs));
      write_reg(REG_RSSI_SCALE, CFG_DATA_W'(scl));
      for (int n = 0; n < FRAMES_PER_PHASE; n++) frame_pending.push_back(random_frame());
      wait_idle();
    end

    // let any stray result show up before judging
    repeat (4 * LINK_LAT) @(posedge clk);

    $display("checked %0d table updates: %0d hits, %0d new neighbors, %0d dropped when full",
             links_checked, hit_count, new_count, full_count);
    $display("%0d register writes over %0d settings, %0d mismatches",
             cfg_writes, RANDOM_PHASES + 1, err_count);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
